@@ rtl/core/vn_pkg.sv @@
// Shared types and constants for the 3D vector normalize pipeline.
`default_nettype none

package vn_pkg;

    // Vector components handled side by side.
    localparam int LANES = 3;

    // One quotient bit per divider stage: quotient reaches 2^32.
    localparam int DIV_STEPS = 33;

    // One root bit per square root stage: root reaches 2^16.
    localparam int ROOT_STEPS = 17;

    // Largest positive Q1.15 code.
    localparam logic [15:0] Q15_MAX = 16'h7FFF;

    // Divider lane: partial remainder and quotient bits so far.
    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] quo;
    } vn_div_lane_t;

    // Divider stage contents.
    typedef struct packed {
        vn_div_lane_t [LANES-1:0] lane;
        logic [31:0]              sum;
        logic [LANES-1:0]         neg;
        logic                     zero;
    } vn_div_t;

    // Square root lane: remaining operand and partial root.
    typedef struct packed {
        logic [32:0] op;
        logic [33:0] res;
    } vn_root_lane_t;

    // Square root stage contents.
    typedef struct packed {
        vn_root_lane_t [LANES-1:0] lane;
        logic [LANES-1:0]          neg;
        logic                      zero;
    } vn_root_t;

    // Finished result.
    typedef struct packed {
        logic [LANES-1:0][15:0] unit;
        logic                   zero;
    } vn_out_t;

endpackage

`default_nettype wire

@@ rtl/core/vector3_normalize.sv @@
// Pipelined 3D vector normalize: signed 16-bit vector in, Q1.15 unit vector out.
//
// Input channel: vec_valid, vec_stall, vec_x, vec_y, vec_z. A transfer happens
// on a rising edge with vec_valid high and vec_stall low.
// Output channel: unit_valid, unit_stall, unit_x, unit_y, unit_z, zero_vector.
// A transfer happens on a rising edge with unit_valid high and unit_stall low.
// Each component is c / sqrt(x*x + y*y + z*z) in Q1.15, rounded to nearest,
// with +1.0 saturating to 32767. A zero vector gives zeros and zero_vector = 1.
// Between input transfer and output transfer lie three front stages
// (magnitude, square, sum), 33 restoring divider stages (one quotient bit
// each), 17 square root stages (one root bit each) and one output stage.
// Throughput is one vector per cycle while the skid register is free; the
// 33-bit compare and subtract in a divider or root stage sets the clock.
// A skid register behind the output stage takes the item that is pushed out
// while unit_stall is high; the pipeline holds, and vec_stall is raised, only
// while that register is occupied. Nothing is lost or repeated under stall.
// Reset (rst_n low, asynchronous) clears every valid bit; no item survives.
`default_nettype none

module vector3_normalize
    import vn_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               vec_valid,
    output logic                    vec_stall,
    input  wire logic signed [15:0] vec_x,
    input  wire logic signed [15:0] vec_y,
    input  wire logic signed [15:0] vec_z,
    output logic                    unit_valid,
    input  wire logic               unit_stall,
    output logic signed [15:0]      unit_x,
    output logic signed [15:0]      unit_y,
    output logic signed [15:0]      unit_z,
    output logic                    zero_vector
);

    // Pipeline moves whenever the skid register is free.
    logic advance;

    logic [LANES-1:0][15:0] vec_in;

    // Front stages.
    logic                   v0_reg;
    logic [LANES-1:0][15:0] abs_reg;
    logic [LANES-1:0]       neg0_reg;
    logic                   v1_reg;
    logic [LANES-1:0][30:0] sq1_reg;
    logic [LANES-1:0]       neg1_reg;
    logic                   v2_reg;
    logic [LANES-1:0][30:0] sq2_reg;
    logic [31:0]            sum2_reg;
    logic [LANES-1:0]       neg2_reg;
    logic                   zero2_reg;

    // Divider and root stages.
    logic [DIV_STEPS-1:0]  div_valid_reg;
    vn_div_t               div_in   [DIV_STEPS];
    vn_div_t               div_next [DIV_STEPS];
    vn_div_t               div_reg  [DIV_STEPS];
    logic [ROOT_STEPS-1:0] root_valid_reg;
    vn_root_t              root_in   [ROOT_STEPS];
    vn_root_t              root_next [ROOT_STEPS];
    vn_root_t              root_reg  [ROOT_STEPS];

    // Output stage and skid.
    logic    fin_valid_reg;
    vn_out_t fin_next;
    vn_out_t fin_reg;
    logic    skid_valid_reg;
    vn_out_t skid_reg;
    vn_out_t out_sel;

    assign advance   = !skid_valid_reg;
    assign vec_stall = skid_valid_reg;
    assign vec_in    = {vec_z, vec_y, vec_x};

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            div_valid_reg  <= '0;
            root_valid_reg <= '0;
            fin_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg         <= vec_valid;
            v1_reg         <= v0_reg;
            v2_reg         <= v1_reg;
            div_valid_reg  <= {div_valid_reg[DIV_STEPS-2:0], v2_reg};
            root_valid_reg <= {root_valid_reg[ROOT_STEPS-2:0], div_valid_reg[DIV_STEPS-1]};
            fin_valid_reg  <= root_valid_reg[ROOT_STEPS-1];
        end
    end

    // Front: magnitudes, squares, sum of squares.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                neg0_reg[l] <= vec_in[l][15];
                abs_reg[l]  <= vec_in[l][15] ? 16'(16'd0 - vec_in[l]) : vec_in[l];
                sq1_reg[l]  <= 31'(32'(abs_reg[l]) * 32'(abs_reg[l]));
                sq2_reg[l]  <= sq1_reg[l];
            end
            neg1_reg  <= neg0_reg;
            neg2_reg  <= neg1_reg;
            sum2_reg  <= 32'(sq1_reg[0]) + 32'(sq1_reg[1]) + 32'(sq1_reg[2]);
            zero2_reg <= (sq1_reg[0] == '0) && (sq1_reg[1] == '0) && (sq1_reg[2] == '0);
        end
    end

    // Divider feed: remainder starts at the square, quotient empty.
    always_comb
    begin
        div_in[0].sum  = sum2_reg;
        div_in[0].neg  = neg2_reg;
        div_in[0].zero = zero2_reg;
        for (int l = 0; l < LANES; l++)
        begin
            div_in[0].lane[l].rem = 32'(sq2_reg[l]);
            div_in[0].lane[l].quo = '0;
        end
    end

    // Restoring divide: quotient = square * 2^32 / sum, one bit per stage.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        if (j > 0)
        begin : g_link
            assign div_in[j] = div_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] trial;
            logic        ge;
            div_next[j] = div_in[j];
            for (int l = 0; l < LANES; l++)
            begin
                // First stage compares the square itself, later ones shift in a zero.
                if (j == 0)
                    trial = {1'b0, div_in[j].lane[l].rem};
                else
                    trial = {div_in[j].lane[l].rem, 1'b0};
                ge = (trial >= {1'b0, div_in[j].sum});
                div_next[j].lane[l].rem = ge ? 32'(trial - {1'b0, div_in[j].sum})
                                             : trial[31:0];
                div_next[j].lane[l].quo = {div_in[j].lane[l].quo[31:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                div_reg[j] <= div_next[j];
        end
    end

    // Root feed: operand is the quotient, root starts at zero.
    always_comb
    begin
        root_in[0].neg  = div_reg[DIV_STEPS-1].neg;
        root_in[0].zero = div_reg[DIV_STEPS-1].zero;
        for (int l = 0; l < LANES; l++)
        begin
            root_in[0].lane[l].op  = div_reg[DIV_STEPS-1].lane[l].quo;
            root_in[0].lane[l].res = '0;
        end
    end

    // Digit-by-digit integer square root, one root bit per stage.
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [33:0] BIT_ONE = 34'd1 << (2 * (ROOT_STEPS - 1 - k));

        if (k > 0)
        begin : g_link
            assign root_in[k] = root_reg[k-1];
        end

        always_comb
        begin
            logic [33:0] trial;
            logic        ge;
            root_next[k] = root_in[k];
            for (int l = 0; l < LANES; l++)
            begin
                trial = root_in[k].lane[l].res + BIT_ONE;
                ge    = ({1'b0, root_in[k].lane[l].op} >= trial);
                root_next[k].lane[l].op  = ge ? 33'(root_in[k].lane[l].op - trial[32:0])
                                              : root_in[k].lane[l].op;
                root_next[k].lane[l].res = ge ? (root_in[k].lane[l].res >> 1) + BIT_ONE
                                              : root_in[k].lane[l].res >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
                root_reg[k] <= root_next[k];
        end
    end

    // Output: n = (root + 1) / 2, then sign, saturation and zero handling.
    always_comb
    begin
        logic [17:0] rp1;
        logic [15:0] mag;
        fin_next.zero = root_reg[ROOT_STEPS-1].zero;
        for (int l = 0; l < LANES; l++)
        begin
            rp1 = {1'b0, root_reg[ROOT_STEPS-1].lane[l].res[16:0]} + 18'd1;
            mag = rp1[16:1];
            if (root_reg[ROOT_STEPS-1].zero)
                fin_next.unit[l] = '0;
            else if (root_reg[ROOT_STEPS-1].neg[l])
                fin_next.unit[l] = 16'(16'd0 - mag);
            else if (mag[15])
                fin_next.unit[l] = Q15_MAX;
            else
                fin_next.unit[l] = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            fin_reg <= fin_next;
    end

    // Skid: hold the result pushed out of the last stage while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (skid_valid_reg)
            skid_valid_reg <= unit_stall;
        else
            skid_valid_reg <= fin_valid_reg && unit_stall;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            skid_reg <= fin_reg;
    end

    assign out_sel     = skid_valid_reg ? skid_reg : fin_reg;
    assign unit_valid  = skid_valid_reg || fin_valid_reg;
    assign unit_x      = out_sel.unit[0];
    assign unit_y      = out_sel.unit[1];
    assign unit_z      = out_sel.unit[2];
    assign zero_vector = out_sel.zero;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the vector3_normalize pipeline.
`timescale 1ns / 1ps

module tb_top
    import vn_pkg::*;
();

    // One normalized vector as it leaves the block
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
    } unit_vec_t;

    // Directed row: input vector, plus a typed-in result where one is given
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 typed;
        unit_vec_t          want;
    } dir_row_t;

    localparam int PIPE_LATENCY = 54;
    localparam int PHASE_ITEMS  = 195;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               vec_valid = 1'b0;
    logic               vec_stall;
    logic signed [15:0] vec_x = '0;
    logic signed [15:0] vec_y = '0;
    logic signed [15:0] vec_z = '0;
    logic               unit_valid;
    logic               unit_stall = 1'b0;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               zero_vector;

    unit_vec_t unit_q[$];
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        sent_cnt = 0;
    int        checked_cnt = 0;
    int        zero_cnt = 0;
    int        sat_cnt = 0;
    int        err_cnt = 0;

    // Directed vectors: axes, extremes, zero, saturation, bit toggles
    dir_row_t directed_rows [20] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{16'sd1,      16'sd0,      16'sd0,      1'b1, '{16'sh7FFF, 16'sd0, 16'sd0, 1'b0}},
        '{16'shFFFF,   16'sd0,      16'sd0,      1'b1, '{16'sh8000, 16'sd0, 16'sd0, 1'b0}},
        '{16'sd0,      16'sd32767,  16'sd0,      1'b1, '{16'sd0, 16'sh7FFF, 16'sd0, 1'b0}},
        '{16'sd0,      16'sd0,      16'sh8000,   1'b1, '{16'sd0, 16'sd0, 16'sh8000, 1'b0}},
        '{16'sh8000,   16'sd0,      16'sd0,      1'b1, '{16'sh8000, 16'sd0, 16'sd0, 1'b0}},
        '{16'sd0,      16'shFFFB,   16'sd0,      1'b1, '{16'sd0, 16'sh8000, 16'sd0, 1'b0}},
        '{16'sd0,      16'sd0,      16'sd100,    1'b1, '{16'sd0, 16'sd0, 16'sh7FFF, 1'b0}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
        '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, '0},
        '{16'sd1,      16'sd1,      16'sd1,      1'b0, '0},
        '{16'shFFFF,   16'sd1,      16'shFFFF,   1'b0, '0},
        '{16'sd3,      16'sd4,      16'sd0,      1'b0, '0},
        '{16'sd1,      16'shFFFF,   16'sd0,      1'b0, '0},
        '{16'sd32767,  16'sd1,      16'sd0,      1'b0, '0},
        '{16'sh8001,   16'sd0,      16'sd1,      1'b0, '0},
        '{16'sd32767,  16'sh8000,   16'sd0,      1'b0, '0},
        '{16'sh8000,   16'sd32767,  16'shFFFF,   1'b0, '0},
        '{16'sh5555,   16'shAAAA,   16'sd0,      1'b0, '0},
        '{16'shAAAA,   16'sh5555,   16'shAAAA,   1'b0, '0}
    };

    vector3_normalize u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .vec_z       (vec_z),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .unit_x      (unit_x),
        .unit_y      (unit_y),
        .unit_z      (unit_z),
        .zero_vector (zero_vector)
    );

    always #2 clk = ~clk;

    // One Q1.15 component: largest n with (2n-1)^2 * S <= c^2 * 2^32
    function automatic logic signed [15:0] q15_component(logic signed [15:0] c,
                                                         longint unsigned sumsq);
        int              ci;
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned odd;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        ci = c;
        mag = (ci < 0) ? longint'(-ci) : longint'(ci);
        rhs = (mag * mag) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * longint'(mid) - 1;
            if (odd * odd * sumsq <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (ci < 0)
            return 16'(65536 - lo);
        if (lo > 32767)
            return Q15_MAX;
        return 16'(lo);
    endfunction

    function automatic unit_vec_t normalize_vec(logic signed [15:0] x,
                                                logic signed [15:0] y,
                                                logic signed [15:0] z);
        unit_vec_t       res;
        longint unsigned sumsq;
        sumsq = longint'(x) * longint'(x) + longint'(y) * longint'(y)
              + longint'(z) * longint'(z);
        if (sumsq == 0)
        begin
            res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end
        else
        begin
            res.x = q15_component(x, sumsq);
            res.y = q15_component(y, sumsq);
            res.z = q15_component(z, sumsq);
            res.zero = 1'b0;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] rand_extreme();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh8001;
            2: return 16'shFFFF;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // Random vector: full range, tiny, on one axis, in one plane, extremes, zero
    task automatic pick_vector(output logic signed [15:0] x,
                               output logic signed [15:0] y,
                               output logic signed [15:0] z);
        int kind;
        int axis;
        kind = $urandom_range(99);
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
        if (kind < 40)
        begin
        end
        else if (kind < 60)
        begin
            x = 16'(int'($urandom_range(6)) - 3);
            y = 16'(int'($urandom_range(6)) - 3);
            z = 16'(int'($urandom_range(6)) - 3);
        end
        else if (kind < 85)
        begin
            // Below 75 one axis is cleared, else all but one
            axis = $urandom_range(2);
            if ((kind < 75) ? (axis == 0) : (axis != 0))
                x = '0;
            if ((kind < 75) ? (axis == 1) : (axis != 1))
                y = '0;
            if ((kind < 75) ? (axis == 2) : (axis != 2))
                z = '0;
        end
        else if (kind < 95)
        begin
            x = rand_extreme();
            y = rand_extreme();
            z = rand_extreme();
        end
        else
        begin
            x = '0;
            y = '0;
            z = '0;
        end
    endtask

    // Drive one vector, hold until transferred, then queue its expected result
    task automatic push_vector(input logic signed [15:0] x,
                               input logic signed [15:0] y,
                               input logic signed [15:0] z,
                               input bit typed,
                               input unit_vec_t typed_want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vec_valid <= 1'b0;
            @(posedge clk);
        end
        vec_valid <= 1'b1;
        vec_x <= x;
        vec_y <= y;
        vec_z <= z;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        unit_q.push_back(typed ? typed_want : normalize_vec(x, y, z));
        sent_cnt++;
    endtask

    // Receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_stall <= 1'b0;
        else
            unit_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each output transfer against the oldest pending vector
    always @(posedge clk)
    begin : unit_monitor
        unit_vec_t want;
        if (rst_n && unit_valid && !unit_stall)
        begin
            if (unit_q.size() == 0)
            begin
                $error("unit transfer with no vector pending");
                err_cnt++;
            end
            else
            begin
                want = unit_q.pop_front();
                checked_cnt++;
                if (unit_x !== want.x)
                begin
                    $error("unit_x: expected %0d, got %0d", want.x, unit_x);
                    err_cnt++;
                end
                if (unit_y !== want.y)
                begin
                    $error("unit_y: expected %0d, got %0d", want.y, unit_y);
                    err_cnt++;
                end
                if (unit_z !== want.z)
                begin
                    $error("unit_z: expected %0d, got %0d", want.z, unit_z);
                    err_cnt++;
                end
                if (zero_vector !== want.zero)
                begin
                    $error("zero_vector: expected %0d, got %0d", want.zero, zero_vector);
                    err_cnt++;
                end
                if (want.zero)
                    zero_cnt++;
                sat_cnt += (want.x == Q15_MAX) + (want.y == Q15_MAX) + (want.z == Q15_MAX);
            end
        end
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        int                 ph;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back
        foreach (directed_rows[i])
            push_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                        directed_rows[i].typed, directed_rows[i].want);

        // Random phases: no idling, sender idle, receiver stalling, both
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 88;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 88;
                end
                default:
                begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                pick_vector(x, y, z);
                push_vector(x, y, z, 1'b0, '0);
            end
            // Hold off until the pipeline has emptied
            vec_valid <= 1'b0;
            do
                @(posedge clk);
            while (unit_q.size() != 0);
        end

        // Catch any stray output past the last result
        stall_pct = 0;
        repeat (PIPE_LATENCY + 10) @(posedge clk);

        $display("Sent %0d vectors, checked %0d results: %0d zero vectors, %0d saturated",
                 sent_cnt, checked_cnt, zero_cnt, sat_cnt);
        $display("components, over four idle and stall mixes with full drains between.");
        if (err_cnt == 0 && unit_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
